/* src/vmbrf_pkg.sv */
// ----------------------------------------------------------------------------
// vmbrf_pkg: shared definitions of the virtio-mmio block register file
// Register offsets, action codes and the state bundle passed between the
// write-side and read-side logic.
// ----------------------------------------------------------------------------
package vmbrf_pkg;

  localparam int unsigned QueueMaxDefault = 128;

  // Configuration port geometry: two registers at byte addresses 0 and 8.
  localparam int unsigned PaddrW = 4;
  localparam int unsigned CfgDataW = 64;

  localparam logic [31:0] MagicWord  = 32'h7472_6976;
  localparam logic [31:0] VendorWord = 32'h5953_5958;
  localparam logic [31:0] VersionWord = 32'd2;
  localparam logic [31:0] DeviceIdBlk = 32'd2;

  // Byte offsets of the register map.
  localparam logic [11:0] OffMagic      = 12'h000;
  localparam logic [11:0] OffVersion    = 12'h004;
  localparam logic [11:0] OffDeviceId   = 12'h008;
  localparam logic [11:0] OffVendor     = 12'h00c;
  localparam logic [11:0] OffDevFeat    = 12'h010;
  localparam logic [11:0] OffDevFeatSel = 12'h014;
  localparam logic [11:0] OffDrvFeat    = 12'h020;
  localparam logic [11:0] OffDrvFeatSel = 12'h024;
  localparam logic [11:0] OffQueueSel   = 12'h030;
  localparam logic [11:0] OffQueueMax   = 12'h034;
  localparam logic [11:0] OffQueueSize  = 12'h038;
  localparam logic [11:0] OffQueueReady = 12'h044;
  localparam logic [11:0] OffNotify     = 12'h050;
  localparam logic [11:0] OffIrqStatus  = 12'h060;
  localparam logic [11:0] OffIrqAck     = 12'h064;
  localparam logic [11:0] OffStatus     = 12'h070;
  localparam logic [11:0] OffDescLo     = 12'h080;
  localparam logic [11:0] OffDescHi     = 12'h084;
  localparam logic [11:0] OffAvailLo    = 12'h090;
  localparam logic [11:0] OffAvailHi    = 12'h094;
  localparam logic [11:0] OffUsedLo     = 12'h0a0;
  localparam logic [11:0] OffUsedHi     = 12'h0a4;
  localparam logic [11:0] OffGeneration = 12'h0fc;
  localparam logic [11:0] OffCapLo      = 12'h100;
  localparam logic [11:0] OffCapHi      = 12'h104;

  typedef enum logic [1:0] {
    ActRead     = 2'd0,
    ActWrite    = 2'd1,
    ActComplete = 2'd2
  } vmbrf_action_e;

  // Configuration registers.
  typedef struct packed {
    logic [63:0] capacity;
    logic        disk_attached;
  } vmbrf_cfg_t;

  // Device state, apart from the queue size whose width follows the queue limit.
  typedef struct packed {
    logic [31:0] dev_feat_sel;
    logic [31:0] drv_feat_sel;
    logic [63:0] drv_features;
    logic [31:0] queue_sel;
    logic        queue_enabled;
    logic [63:0] desc_addr;
    logic [63:0] avail_addr;
    logic [63:0] used_addr;
    logic        irq_used;
    logic [31:0] device_status;
    logic [7:0]  generation;
  } vmbrf_state_t;

  // Per-beat outcome of the write side.
  typedef struct packed {
    logic error;
    logic irq;
    logic notify;
  } vmbrf_wres_t;

endpackage

/* src/vmbrf_apb_cfg.sv */
// ----------------------------------------------------------------------------
// vmbrf_apb_cfg: configuration registers behind an APB-style port
// Holds the disk capacity and the disk-present flag.
// ----------------------------------------------------------------------------
module vmbrf_apb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vmbrf_pkg::PaddrW-1:0]  paddr,
  input  logic [vmbrf_pkg::CfgDataW-1:0] pwdata,
  output logic [vmbrf_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output vmbrf_pkg::vmbrf_cfg_t         cfg_o
);
  import vmbrf_pkg::*;

  logic        wr_en;
  logic [63:0] capacity_q;
  logic        disk_attached_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Bit 3 of the address picks the register; the low bits are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q      <= '0;
      disk_attached_q <= 1'b0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        disk_attached_q <= pwdata[0];
      end else begin
        capacity_q <= pwdata;
      end
    end
  end

  assign prdata = paddr[3] ? {{(CfgDataW-1){1'b0}}, disk_attached_q} : capacity_q;

  assign cfg_o.capacity      = capacity_q;
  assign cfg_o.disk_attached = disk_attached_q;

endmodule

/* src/vmbrf_csr.sv */
// ----------------------------------------------------------------------------
// vmbrf_csr: device state and write decode
// Applies the low word and then the high word of a write beat, handles
// completion events and reports error, interrupt and notify for the beat.
// ----------------------------------------------------------------------------
module vmbrf_csr #(
  parameter int unsigned QueueMax = vmbrf_pkg::QueueMaxDefault,
  parameter int unsigned QsizeW   = $clog2(QueueMax + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [1:0]              action_i,
  input  logic [11:0]             base_i,
  input  logic [63:0]             wdata_i,
  input  logic [7:0]              wmask_i,
  input  vmbrf_pkg::vmbrf_cfg_t   cfg_i,
  output vmbrf_pkg::vmbrf_state_t state_o,
  output logic [QsizeW-1:0]       queue_size_o,
  output vmbrf_pkg::vmbrf_wres_t  wres_o
);
  import vmbrf_pkg::*;

  localparam logic [31:0] QueueMaxW = 32'(QueueMax);

  vmbrf_state_t      state_q, state_d;
  logic [QsizeW-1:0] qsize_q, qsize_d;

  function automatic logic [31:0] merge_bytes(input logic [31:0] cur,
                                              input logic [31:0] val,
                                              input logic [3:0]  lanes);
    logic [31:0] m;
    for (int i = 0; i < 4; i++) begin
      m[8*i +: 8] = {8{lanes[i]}};
    end
    return (cur & ~m) | (val & m);
  endfunction

  always_comb begin
    logic [11:0] woff;
    logic [31:0] wval;
    logic [31:0] merged;
    logic [3:0]  wlanes;
    logic        wen;
    logic        bad_queue;

    state_d = state_q;
    qsize_d = qsize_q;
    wres_o  = '0;

    // The two words are applied in order, so the high word sees the low
    // word's update, exactly as two back-to-back bus writes would.
    for (int w = 0; w < 2; w++) begin
      woff   = (w == 0) ? base_i : (base_i | 12'h004);
      wval   = (w == 0) ? wdata_i[31:0] : wdata_i[63:32];
      wlanes = (w == 0) ? wmask_i[3:0] : wmask_i[7:4];
      wen    = (action_i == ActWrite) && (wlanes != 4'd0);
      merged = '0;
      bad_queue = 1'b0;
      if (wen) begin
        case (woff)
          OffDevFeatSel: state_d.dev_feat_sel = merge_bytes(state_d.dev_feat_sel, wval, wlanes);
          OffDrvFeat: begin
            if (state_d.drv_feat_sel == 32'd0) begin
              state_d.drv_features[31:0] =
                merge_bytes(state_d.drv_features[31:0], wval, wlanes);
            end else if (state_d.drv_feat_sel == 32'd1) begin
              state_d.drv_features[63:32] =
                merge_bytes(state_d.drv_features[63:32], wval, wlanes);
            end
          end
          OffDrvFeatSel: state_d.drv_feat_sel = merge_bytes(state_d.drv_feat_sel, wval, wlanes);
          OffQueueSel:   state_d.queue_sel = merge_bytes(state_d.queue_sel, wval, wlanes);
          OffQueueSize: begin
            merged = merge_bytes(32'(qsize_d), wval, wlanes);
            if (merged > QueueMaxW) begin
              wres_o.error = 1'b1;
            end else begin
              qsize_d = merged[QsizeW-1:0];
            end
          end
          OffQueueReady: begin
            merged = merge_bytes({31'd0, state_d.queue_enabled}, wval, wlanes);
            state_d.queue_enabled = merged[0];
          end
          OffNotify: begin
            bad_queue = !cfg_i.disk_attached || (state_d.queue_sel != 32'd0) ||
                        !state_d.queue_enabled || (qsize_d == '0) ||
                        (32'(qsize_d) > QueueMaxW) || (state_d.desc_addr == 64'd0) ||
                        (state_d.avail_addr == 64'd0) || (state_d.used_addr == 64'd0);
            if (bad_queue) begin
              wres_o.error = 1'b1;
            end else begin
              wres_o.notify = 1'b1;
            end
          end
          OffIrqAck: begin
            merged = merge_bytes(32'd0, wval, wlanes);
            state_d.irq_used = state_d.irq_used & ~merged[0];
          end
          OffStatus: begin
            merged = merge_bytes(state_d.device_status, wval, wlanes);
            if (merged == 32'd0) begin
              // Writing zero resets the device; only the generation survives.
              state_d.dev_feat_sel  = '0;
              state_d.drv_feat_sel  = '0;
              state_d.drv_features  = '0;
              state_d.queue_sel     = '0;
              state_d.queue_enabled = 1'b0;
              state_d.desc_addr     = '0;
              state_d.avail_addr    = '0;
              state_d.used_addr     = '0;
              state_d.irq_used      = 1'b0;
              state_d.device_status = '0;
              state_d.generation    = state_d.generation + 8'd1;
              qsize_d               = '0;
            end else begin
              state_d.device_status = merged;
            end
          end
          OffDescLo:  state_d.desc_addr[31:0]   = merge_bytes(state_d.desc_addr[31:0], wval, wlanes);
          OffDescHi:  state_d.desc_addr[63:32]  = merge_bytes(state_d.desc_addr[63:32], wval, wlanes);
          OffAvailLo: state_d.avail_addr[31:0]  = merge_bytes(state_d.avail_addr[31:0], wval, wlanes);
          OffAvailHi: state_d.avail_addr[63:32] = merge_bytes(state_d.avail_addr[63:32], wval, wlanes);
          OffUsedLo:  state_d.used_addr[31:0]   = merge_bytes(state_d.used_addr[31:0], wval, wlanes);
          OffUsedHi:  state_d.used_addr[63:32]  = merge_bytes(state_d.used_addr[63:32], wval, wlanes);
          default:    wres_o.error = 1'b1;
        endcase
      end
    end

    if (action_i == ActComplete) begin
      state_d.irq_used = 1'b1;
    end

    wres_o.irq = state_d.irq_used;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      qsize_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      qsize_q <= qsize_d;
    end
  end

  assign state_o      = state_q;
  assign queue_size_o = qsize_q;

endmodule

/* src/vmbrf_read_mux.sv */
// ----------------------------------------------------------------------------
// vmbrf_read_mux: read data of an aligned register pair
// Decodes the low and the high word of a read beat from the current state.
// ----------------------------------------------------------------------------
module vmbrf_read_mux #(
  parameter int unsigned QueueMax = vmbrf_pkg::QueueMaxDefault,
  parameter int unsigned QsizeW   = $clog2(QueueMax + 1)
) (
  input  logic [1:0]              action_i,
  input  logic [11:0]             base_i,
  input  vmbrf_pkg::vmbrf_state_t state_i,
  input  logic [QsizeW-1:0]       queue_size_i,
  input  vmbrf_pkg::vmbrf_cfg_t   cfg_i,
  output logic [63:0]             rdata_o
);
  import vmbrf_pkg::*;

  logic [31:0] words [2];

  always_comb begin
    logic [11:0] roff;
    for (int w = 0; w < 2; w++) begin
      roff = (w == 0) ? base_i : (base_i | 12'h004);
      case (roff)
        OffMagic:      words[w] = MagicWord;
        OffVersion:    words[w] = VersionWord;
        OffDeviceId:   words[w] = cfg_i.disk_attached ? DeviceIdBlk : 32'd0;
        OffVendor:     words[w] = VendorWord;
        OffDevFeat:    words[w] = {31'd0, state_i.dev_feat_sel == 32'd1};
        OffDevFeatSel: words[w] = state_i.dev_feat_sel;
        OffDrvFeat:    words[w] = (state_i.drv_feat_sel == 32'd0) ?
                                  state_i.drv_features[31:0] : state_i.drv_features[63:32];
        OffDrvFeatSel: words[w] = state_i.drv_feat_sel;
        OffQueueSel:   words[w] = state_i.queue_sel;
        OffQueueMax:   words[w] = ((state_i.queue_sel == 32'd0) && cfg_i.disk_attached) ?
                                  32'(QueueMax) : 32'd0;
        OffQueueSize:  words[w] = 32'(queue_size_i);
        OffQueueReady: words[w] = {31'd0, state_i.queue_enabled};
        OffIrqStatus:  words[w] = {31'd0, state_i.irq_used};
        OffStatus:     words[w] = state_i.device_status;
        OffDescLo:     words[w] = state_i.desc_addr[31:0];
        OffDescHi:     words[w] = state_i.desc_addr[63:32];
        OffAvailLo:    words[w] = state_i.avail_addr[31:0];
        OffAvailHi:    words[w] = state_i.avail_addr[63:32];
        OffUsedLo:     words[w] = state_i.used_addr[31:0];
        OffUsedHi:     words[w] = state_i.used_addr[63:32];
        OffGeneration: words[w] = {24'd0, state_i.generation};
        OffCapLo:      words[w] = cfg_i.capacity[31:0];
        OffCapHi:      words[w] = cfg_i.capacity[63:32];
        default:       words[w] = 32'd0;
      endcase
    end
  end

  assign rdata_o = (action_i == ActRead) ? {words[1], words[0]} : 64'd0;

endmodule

/* src/virtio_mmio_block_register_file_core.sv */
// ----------------------------------------------------------------------------
// virtio_mmio_block_register_file_core: virtio-mmio v2 block register file
// Top level: input register, register file logic and result register.
// ----------------------------------------------------------------------------
// The input channel carries one beat per bus access or completion event:
// action (read, write or queue completion), an offset that is aligned down to
// eight bytes, 64 bits of write data and eight byte enables. Every input beat
// produces exactly one result beat with the read data of the register pair,
// an error flag for rejected or unmapped writes, the interrupt line after the
// access and a one-beat notify request for a well-formed queue notify.
// A beat is captured in an input register, goes through one level of decode
// and merge logic that also updates the device state, and lands in the result
// register; one beat is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more beat and only then does in_stall_o rise.
// Reset clears all device state, the generation count and the configuration
// registers; no clearing pass is needed, so beats are taken straight away.
// The APB-style port holds the capacity (address 0) and the disk-present flag
// (address 8); the user writes it only while no beat is in flight, unchecked.
// ----------------------------------------------------------------------------
module virtio_mmio_block_register_file_core #(
  parameter int unsigned QueueMax = vmbrf_pkg::QueueMaxDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [11:0]                    offset_i,
  input  logic [63:0]                    wdata_i,
  input  logic [7:0]                     wmask_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [63:0]                    rdata_o,
  output logic                           error_o,
  output logic                           irq_o,
  output logic                           notify_request_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vmbrf_pkg::PaddrW-1:0]   paddr,
  input  logic [vmbrf_pkg::CfgDataW-1:0] pwdata,
  output logic [vmbrf_pkg::CfgDataW-1:0] prdata,
  output logic                           pready
);
  import vmbrf_pkg::*;

  // The queue size register only needs to hold values up to the limit.
  localparam int unsigned QsizeW = $clog2(QueueMax + 1);

  vmbrf_cfg_t        cfg;
  vmbrf_state_t      state;
  vmbrf_wres_t       wres;
  logic [QsizeW-1:0] queue_size;
  logic [63:0]       rdata;
  logic [11:0]       base;

  // Input register.
  logic        in_valid_q;
  logic [1:0]  action_q;
  logic [11:0] offset_q;
  logic [63:0] wdata_q;
  logic [7:0]  wmask_q;

  // Result register.
  logic        out_valid_q;
  logic [63:0] rdata_q;
  logic        error_q;
  logic        irq_q;
  logic        notify_q;

  logic out_free;
  logic fire;
  logic in_take;

  // The result register can load when it is empty or its beat leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= action_i;
      offset_q <= offset_i;
      wdata_q  <= wdata_i;
      wmask_q  <= wmask_i;
    end
  end

  // The low three bits of the offset never select anything.
  assign base = {offset_q[11:3], 3'b000};

  vmbrf_apb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vmbrf_csr #(
    .QueueMax (QueueMax),
    .QsizeW   (QsizeW)
  ) u_csr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .action_i     (action_q),
    .base_i       (base),
    .wdata_i      (wdata_q),
    .wmask_i      (wmask_q),
    .cfg_i        (cfg),
    .state_o      (state),
    .queue_size_o (queue_size),
    .wres_o       (wres)
  );

  // Reads see the state before this beat; reads never change it.
  vmbrf_read_mux #(
    .QueueMax (QueueMax),
    .QsizeW   (QsizeW)
  ) u_read (
    .action_i     (action_q),
    .base_i       (base),
    .state_i      (state),
    .queue_size_i (queue_size),
    .cfg_i        (cfg),
    .rdata_o      (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q  <= rdata;
      error_q  <= wres.error;
      irq_q    <= wres.irq;
      notify_q <= wres.notify;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rdata_o          = rdata_q;
  assign error_o          = error_q;
  assign irq_o            = irq_q;
  assign notify_request_o = notify_q;

`ifndef SYNTH
  // A held input beat is never dropped while it waits for the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q)
    else $error("input beat lost while waiting");

  // Only writes can be rejected or raise a notify request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (action_q != ActWrite) |-> !wres.error && !wres.notify)
    else $error("error or notify on a beat that is not a write");

  // Only reads return data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (action_q != ActRead) |-> rdata == 64'd0)
    else $error("read data on a beat that is not a read");

  // A new result only appears when a beat has passed the logic stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("result beat without a source beat");
`endif

endmodule
